### rtl/core/filter_bank_template_matcher_defines.svh
// ----------------------------------------------------------------------------
// filter_bank_template_matcher assertion macros
// Shared concurrent assertion forms, sampled on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef FILTER_BANK_TEMPLATE_MATCHER_DEFINES_SVH
`define FILTER_BANK_TEMPLATE_MATCHER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define FBTM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define FBTM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/fbtm_pkg.sv
// ----------------------------------------------------------------------------
// fbtm_pkg
// Types and constants of the filter-bank template matcher.
// ----------------------------------------------------------------------------
package fbtm_pkg;

	localparam int NUM_CLASSES_DEF = 4;
	localparam int MAX_SAMPLES_DEF = 255;

	localparam int NUM_BANDS   = 4;
	localparam int BAND_W      = 8;
	localparam int SUM_W       = 16;
	localparam int CNT_W       = 8;
	localparam int TOL_W       = 16;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 8;

	localparam logic [TOL_W-1:0] TOL_RESET = 16'd3264;

	localparam logic REQ_TRAIN = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [1:0] STATUS_SINGLE = 2'd0;
	localparam logic [1:0] STATUS_NONE   = 2'd1;
	localparam logic [1:0] STATUS_MULTI  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRAIN_RD,
		ST_TRAIN_WR,
		ST_QUERY_DIV,
		ST_CLASS_RD,
		ST_CLASS_DIV,
		ST_CLASS_CMP,
		ST_EMIT
	} state_t;

endpackage

### rtl/core/filter_bank_template_matcher.sv
// ----------------------------------------------------------------------------
// filter_bank_template_matcher
// Streams in band samples. A training request (tuser 0) adds one sample to
// a class template; a query request (tuser 1) adds to the query, and tlast on
// a query runs the match. Training reads and then writes the template row;
// a non-last query leaves the sequencer idle. The match uses one shared
// divider that forms every 8.8 mean, integer byte then fraction byte, eight
// quotient bits a cycle, and a compare step per class band; s_axis_tready is
// low meanwhile. The result sits in an output register; while the receiver
// stalls the next match waits only for that register to free. Reset clears
// counts and the query at once (template rows read as zero while their count
// is 0) and loads the tolerance with 3264. cfg_wr_en writes the tolerance.
// ----------------------------------------------------------------------------
module filter_bank_template_matcher #(
	parameter int NUM_CLASSES = fbtm_pkg::NUM_CLASSES_DEF,
	parameter int MAX_SAMPLES = fbtm_pkg::MAX_SAMPLES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [fbtm_pkg::TOL_W-1:0]         cfg_wr_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// class_index[1:0], band_0[9:2], band_1[17:10], band_2[25:18],
	// band_3[33:26], zero fill
	input  logic [fbtm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// req_type
	input  logic                               s_axis_tuser,
	// last_of_query
	input  logic                               s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// matched_class[1:0], zero fill
	output logic [fbtm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// match_status[1:0]
	output logic [1:0]                         m_axis_tuser
);

	localparam int CW     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int NB     = fbtm_pkg::NUM_BANDS;
	localparam int SW     = fbtm_pkg::SUM_W;
	localparam int BW     = fbtm_pkg::BAND_W;
	localparam int ROW_W  = NB * SW;
	localparam logic [CW-1:0] LAST_C = CW'(NUM_CLASSES - 1);
	localparam logic [fbtm_pkg::CNT_W-1:0] MAX_CNT = fbtm_pkg::CNT_W'(MAX_SAMPLES);
	localparam logic [1:0] LAST_B = 2'(NB - 1);

	// eight restoring divide steps: returns {remainder, quotient byte}
	function automatic logic [15:0] div_step8(input logic [7:0] rem_in,
		input logic [7:0] bits, input logic [7:0] den);
		logic [8:0] t;
		logic [7:0] r;
		logic [7:0] q;
		r = rem_in;
		q = '0;
		for (int i = 7; i >= 0; i--) begin
			t = {r, bits[i]};
			if (t >= {1'b0, den}) begin
				t = t - {1'b0, den};
				q[i] = 1'b1;
			end
			r = t[7:0];
		end
		return {r, q};
	endfunction

	fbtm_pkg::state_t state_q, state_d;

	logic [fbtm_pkg::TOL_W-1:0]  tol_q;
	logic [1:0]                  band_q;
	logic                        phase_q;
	logic [CW-1:0]               cls_q;
	logic [CW-1:0]               c_q;
	logic [BW-1:0]               band_in_q [NB];
	logic [SW-1:0]               qsum_q [NB];
	logic [fbtm_pkg::CNT_W-1:0]  qcnt_q;
	logic [fbtm_pkg::CNT_W-1:0]  cnt_q [NUM_CLASSES];
	logic [ROW_W-1:0]            tmpl_mem [NUM_CLASSES];
	logic [ROW_W-1:0]            rd_q;
	logic [7:0]                  qhi_q;
	logic [7:0]                  rem_q;
	logic [SW-1:0]               qmean_q [NB];
	logic [SW-1:0]               mean_q;
	logic                        ok_q;
	logic                        any_q;
	logic                        multi_q;
	logic [CW-1:0]               first_q;
	logic                        out_valid_q;
	logic [1:0]                  out_status_q;
	logic [1:0]                  out_class_q;

	logic                        in_fire;
	logic [1:0]                  in_class;
	logic [BW-1:0]               in_band [NB];
	logic                        in_cls_ok;
	logic [CW-1:0]               cnt_addr;
	logic [fbtm_pkg::CNT_W-1:0]  cnt_sel;
	logic [SW-1:0]               div_sum;
	logic [7:0]                  div_den;
	logic [15:0]                 div_out;
	logic [SW-1:0]               mean_full;
	logic                        band_ok;
	logic                        class_ok;
	logic                        out_free;
	logic [ROW_W-1:0]            wr_row;

	// control outputs of the sequencer
	logic rd_en, wr_en, emit;

	assign in_class = s_axis_tdata[1:0];
	always_comb begin
		for (int b = 0; b < NB; b++) begin
			in_band[b] = s_axis_tdata[2 + b*BW +: BW];
		end
	end
	assign in_cls_ok = ({30'd0, in_class} < 32'(NUM_CLASSES));
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;

	assign cnt_addr = (state_q == fbtm_pkg::ST_TRAIN_RD || state_q == fbtm_pkg::ST_TRAIN_WR)
		? cls_q : c_q;
	assign cnt_sel  = cnt_q[cnt_addr];

	// shared divider operands
	assign div_sum = (state_q == fbtm_pkg::ST_QUERY_DIV) ? qsum_q[band_q]
		: rd_q[band_q*SW +: SW];
	assign div_den = (state_q == fbtm_pkg::ST_QUERY_DIV) ? qcnt_q : cnt_sel;
	assign div_out = div_step8(phase_q ? rem_q : div_sum[15:8],
		phase_q ? 8'd0 : div_sum[7:0], div_den);
	assign mean_full = (div_den == '0) ? '0 : {qhi_q, div_out[7:0]};

	assign band_ok  = (mean_q >= qmean_q[band_q]) ? ((mean_q - qmean_q[band_q]) <= tol_q)
		: ((qmean_q[band_q] - mean_q) <= tol_q);
	assign class_ok = ok_q && band_ok;

	always_comb begin
		for (int b = 0; b < NB; b++) begin
			wr_row[b*SW +: SW] = ((cnt_sel == '0) ? SW'(0) : rd_q[b*SW +: SW])
				+ {{(SW-BW){1'b0}}, band_in_q[b]};
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fbtm_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (s_axis_tuser == fbtm_pkg::REQ_TRAIN) begin
						if (in_cls_ok) begin
							state_d = fbtm_pkg::ST_TRAIN_RD;
						end
					end else if (s_axis_tlast) begin
						state_d = fbtm_pkg::ST_QUERY_DIV;
					end
				end
			end
			fbtm_pkg::ST_TRAIN_RD:  state_d = fbtm_pkg::ST_TRAIN_WR;
			fbtm_pkg::ST_TRAIN_WR:  state_d = fbtm_pkg::ST_IDLE;
			fbtm_pkg::ST_QUERY_DIV: begin
				if (phase_q && band_q == LAST_B) begin
					state_d = fbtm_pkg::ST_CLASS_RD;
				end
			end
			fbtm_pkg::ST_CLASS_RD: begin
				if (cnt_sel != '0) begin
					state_d = fbtm_pkg::ST_CLASS_DIV;
				end else if (c_q == LAST_C) begin
					state_d = fbtm_pkg::ST_EMIT;
				end
			end
			fbtm_pkg::ST_CLASS_DIV: begin
				if (phase_q) begin
					state_d = fbtm_pkg::ST_CLASS_CMP;
				end
			end
			fbtm_pkg::ST_CLASS_CMP: begin
				if (band_q != LAST_B) begin
					state_d = fbtm_pkg::ST_CLASS_DIV;
				end else if (c_q == LAST_C) begin
					state_d = fbtm_pkg::ST_EMIT;
				end else begin
					state_d = fbtm_pkg::ST_CLASS_RD;
				end
			end
			fbtm_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = fbtm_pkg::ST_IDLE;
				end
			end
			default: state_d = fbtm_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		rd_en         = 1'b0;
		wr_en         = 1'b0;
		emit          = 1'b0;
		unique case (state_q)
			fbtm_pkg::ST_IDLE:      s_axis_tready = 1'b1;
			fbtm_pkg::ST_TRAIN_RD:  rd_en = 1'b1;
			fbtm_pkg::ST_TRAIN_WR:  wr_en = (cnt_sel < MAX_CNT);
			fbtm_pkg::ST_QUERY_DIV: ;
			fbtm_pkg::ST_CLASS_RD:  rd_en = 1'b1;
			fbtm_pkg::ST_CLASS_DIV: ;
			fbtm_pkg::ST_CLASS_CMP: ;
			fbtm_pkg::ST_EMIT:      emit = out_free;
			default: ;
		endcase
	end

	// template memory, one row of band sums per class
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tmpl_mem[cls_q] <= wr_row;
		end
		if (rd_en) begin
			rd_q <= tmpl_mem[cnt_addr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cls_q <= CW'(in_class);
			for (int b = 0; b < NB; b++) begin
				band_in_q[b] <= in_band[b];
			end
		end
		if (!phase_q) begin
			qhi_q <= div_out[7:0];
		end
		rem_q <= div_out[15:8];
		if (state_q == fbtm_pkg::ST_QUERY_DIV && phase_q) begin
			qmean_q[band_q] <= mean_full;
		end
		if (state_q == fbtm_pkg::ST_CLASS_DIV && phase_q) begin
			mean_q <= mean_full;
		end
		if (emit) begin
			out_status_q <= any_q ? (multi_q ? fbtm_pkg::STATUS_MULTI : fbtm_pkg::STATUS_SINGLE)
				: fbtm_pkg::STATUS_NONE;
			out_class_q  <= (any_q && !multi_q) ? 2'(first_q) : 2'd0;
		end
	end

	// control state, reset asynchronously
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fbtm_pkg::ST_IDLE;
			tol_q       <= fbtm_pkg::TOL_RESET;
			band_q      <= '0;
			phase_q     <= 1'b0;
			c_q         <= '0;
			qcnt_q      <= '0;
			ok_q        <= 1'b0;
			any_q       <= 1'b0;
			multi_q     <= 1'b0;
			first_q     <= '0;
			out_valid_q <= 1'b0;
			for (int b = 0; b < NB; b++) begin
				qsum_q[b] <= '0;
			end
			for (int c = 0; c < NUM_CLASSES; c++) begin
				cnt_q[c] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				tol_q <= cfg_wr_data;
			end

			if (in_fire && s_axis_tuser == fbtm_pkg::REQ_QUERY) begin
				if (qcnt_q < MAX_CNT) begin
					for (int b = 0; b < NB; b++) begin
						qsum_q[b] <= qsum_q[b] + {{(SW-BW){1'b0}}, in_band[b]};
					end
					qcnt_q <= qcnt_q + 1'b1;
				end
				band_q  <= '0;
				phase_q <= 1'b0;
				c_q     <= '0;
				any_q   <= 1'b0;
				multi_q <= 1'b0;
			end

			if (wr_en) begin
				cnt_q[cls_q] <= cnt_sel + 1'b1;
			end

			unique case (state_q)
				fbtm_pkg::ST_QUERY_DIV: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						band_q <= band_q + 1'b1;
					end
				end
				fbtm_pkg::ST_CLASS_RD: begin
					band_q  <= '0;
					phase_q <= 1'b0;
					ok_q    <= 1'b1;
					if (cnt_sel == '0 && c_q != LAST_C) begin
						c_q <= c_q + 1'b1;
					end
				end
				fbtm_pkg::ST_CLASS_DIV: phase_q <= !phase_q;
				fbtm_pkg::ST_CLASS_CMP: begin
					ok_q <= class_ok;
					if (band_q == LAST_B) begin
						if (class_ok) begin
							if (!any_q) begin
								first_q <= c_q;
							end else begin
								multi_q <= 1'b1;
							end
							any_q <= 1'b1;
						end
						if (c_q != LAST_C) begin
							c_q <= c_q + 1'b1;
						end
					end else begin
						band_q <= band_q + 1'b1;
					end
				end
				default: ;
			endcase

			if (emit) begin
				out_valid_q <= 1'b1;
				qcnt_q      <= '0;
				for (int b = 0; b < NB; b++) begin
					qsum_q[b] <= '0;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(fbtm_pkg::OUT_TDATA_W-2){1'b0}}, out_class_q};
	assign m_axis_tuser  = out_status_q;

endmodule

### rtl/core/fbtm_checker.sv
// ----------------------------------------------------------------------------
// fbtm_checker
// Port-level checks of the template matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "filter_bank_template_matcher_defines.svh"

module fbtm_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic                               s_axis_tuser,
	input logic                               s_axis_tlast,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [fbtm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input logic [1:0]                         m_axis_tuser
);

	logic s_fire;

	assign s_fire = s_axis_tvalid && s_axis_tready;

	// a stalled result stays put
	`FBTM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"result changed while stalled")

	// class index only reported with a single match
	`FBTM_ASSERT_SAME(a_class_zero, m_axis_tvalid && (m_axis_tuser != fbtm_pkg::STATUS_SINGLE),
		m_axis_tdata[1:0] == 2'd0, "class index set without a single match")

	// matching keeps the input side busy
	`FBTM_ASSERT_NEXT(a_busy_on_match,
		s_fire && (s_axis_tuser == fbtm_pkg::REQ_QUERY) && s_axis_tlast,
		!s_axis_tready, "input ready right after a last query request")

	// a training request never produces a result
	`FBTM_ASSERT_NEXT(a_train_silent,
		s_fire && (s_axis_tuser == fbtm_pkg::REQ_TRAIN) && !m_axis_tvalid,
		!m_axis_tvalid, "result after a training request")

endmodule

bind filter_bank_template_matcher fbtm_checker u_fbtm_checker (.*);

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for filter_bank_template_matcher. Training and query
// requests stream in with random gaps while the result side stalls at random.
// A behavioral model of the template store tracks class sums, counts and the
// query accumulator. It predicts the verdict of every closing query, and the
// monitor checks each verdict in order. Tolerance settings go from zero to
// full scale between phases, and the sample limit is driven on both a class
// and the query.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = 80;

	typedef struct packed {
		logic                          req;
		logic [1:0]                    cls;
		logic [fbtm_pkg::NUM_BANDS-1:0][fbtm_pkg::BAND_W-1:0] band;
		logic                          last;
	} sample_t;

	typedef struct packed {
		logic [1:0] status;
		logic [1:0] cls;
	} verdict_t;

	logic                             clk           = 1'b0;
	logic                             arst_n        = 1'b0;
	logic                             cfg_wr_en     = 1'b0;
	logic [fbtm_pkg::TOL_W-1:0]       cfg_wr_data   = '0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [fbtm_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                             s_axis_tuser  = 1'b0;
	logic                             s_axis_tlast  = 1'b0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [fbtm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic [1:0]                       m_axis_tuser;

	filter_bank_template_matcher dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #1 clk = ~clk;

	// template store model
	logic [fbtm_pkg::SUM_W-1:0] tmpl_sum [fbtm_pkg::NUM_CLASSES_DEF][fbtm_pkg::NUM_BANDS];
	logic [fbtm_pkg::CNT_W-1:0] tmpl_cnt [fbtm_pkg::NUM_CLASSES_DEF];
	logic [fbtm_pkg::SUM_W-1:0] qry_sum  [fbtm_pkg::NUM_BANDS];
	logic [fbtm_pkg::CNT_W-1:0] qry_cnt;
	logic [fbtm_pkg::TOL_W-1:0] tolerance;

	sample_t  pending_requests[$];
	verdict_t expected_verdicts[$];
	sample_t  cur_req;
	verdict_t want;
	logic [7:0] center [fbtm_pkg::NUM_CLASSES_DEF][fbtm_pkg::NUM_BANDS];

	int n_queued   = 0;
	int n_accepted = 0;
	int mismatches = 0;
	int tx_gap     = 0;
	int rx_stall   = 0;
	int idle_cycles = 0;
	bit calm       = 1'b0;

	initial begin
		for (int c = 0; c < fbtm_pkg::NUM_CLASSES_DEF; c++) begin
			for (int b = 0; b < fbtm_pkg::NUM_BANDS; b++)
				tmpl_sum[c][b] = '0;
			tmpl_cnt[c] = '0;
		end
		for (int b = 0; b < fbtm_pkg::NUM_BANDS; b++)
			qry_sum[b] = '0;
		qry_cnt   = '0;
		tolerance = fbtm_pkg::TOL_RESET;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic logic [23:0] band_mean(input logic [fbtm_pkg::SUM_W-1:0] sum,
			input logic [fbtm_pkg::CNT_W-1:0] cnt);
		logic [23:0] num;
		if (cnt == 0)
			return '0;
		num = {sum, 8'h00};
		return num / {16'h0, cnt};
	endfunction

	// update the model with one accepted request, queue a verdict on a closing query
	task automatic apply_request(input sample_t s);
		logic [23:0] qmean [fbtm_pkg::NUM_BANDS];
		logic [23:0] cmean;
		logic [23:0] diff;
		int          hits;
		logic [1:0]  first;
		logic        ok;
		verdict_t    v;
		hits  = 0;
		first = '0;
		if (s.req == fbtm_pkg::REQ_TRAIN) begin
			if (s.cls < fbtm_pkg::NUM_CLASSES_DEF
					&& tmpl_cnt[s.cls] < fbtm_pkg::MAX_SAMPLES_DEF) begin
				for (int b = 0; b < fbtm_pkg::NUM_BANDS; b++)
					tmpl_sum[s.cls][b] = tmpl_sum[s.cls][b] + {8'h00, s.band[b]};
				tmpl_cnt[s.cls] = tmpl_cnt[s.cls] + 1'b1;
			end
			return;
		end
		if (qry_cnt < fbtm_pkg::MAX_SAMPLES_DEF) begin
			for (int b = 0; b < fbtm_pkg::NUM_BANDS; b++)
				qry_sum[b] = qry_sum[b] + {8'h00, s.band[b]};
			qry_cnt = qry_cnt + 1'b1;
		end
		if (!s.last)
			return;
		for (int b = 0; b < fbtm_pkg::NUM_BANDS; b++)
			qmean[b] = band_mean(qry_sum[b], qry_cnt);
		for (int c = 0; c < fbtm_pkg::NUM_CLASSES_DEF; c++) begin
			// an untrained class never matches
			ok = (tmpl_cnt[c] != 0);
			for (int b = 0; b < fbtm_pkg::NUM_BANDS; b++) begin
				cmean = band_mean(tmpl_sum[c][b], tmpl_cnt[c]);
				diff  = (cmean > qmean[b]) ? cmean - qmean[b] : qmean[b] - cmean;
				if (diff > {8'h00, tolerance})
					ok = 1'b0;
			end
			if (ok) begin
				if (hits == 0)
					first = c[1:0];
				hits++;
			end
		end
		if (hits == 1) begin
			v.status = fbtm_pkg::STATUS_SINGLE;
			v.cls    = first;
		end else if (hits == 0) begin
			v.status = fbtm_pkg::STATUS_NONE;
			v.cls    = '0;
		end else begin
			v.status = fbtm_pkg::STATUS_MULTI;
			v.cls    = '0;
		end
		expected_verdicts.push_back(v);
		for (int b = 0; b < fbtm_pkg::NUM_BANDS; b++)
			qry_sum[b] = '0;
		qry_cnt = '0;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				apply_request(cur_req);
				n_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap == 0 && !calm && pending_requests.size() > 0
						&& $urandom_range(0, 5) == 0)
					tx_gap = $urandom_range(1, 16);
				if (tx_gap > 0) begin
					tx_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					cur_req = pending_requests.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {6'b0, cur_req.band[3], cur_req.band[2],
						cur_req.band[1], cur_req.band[0], cur_req.cls};
					s_axis_tuser  <= cur_req.req;
					s_axis_tlast  <= cur_req.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// verdict monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch($sformatf("unexpected verdict status %0d class %0d",
						m_axis_tuser, m_axis_tdata));
				end else begin
					want = expected_verdicts.pop_front();
					if (m_axis_tuser !== want.status)
						report_mismatch($sformatf("match_status %0d, want %0d",
							m_axis_tuser, want.status));
					if (m_axis_tdata !== {6'b0, want.cls})
						report_mismatch($sformatf("matched_class field 0x%0h, want %0d",
							m_axis_tdata, want.cls));
				end
			end
			if (rx_stall == 0 && !calm && $urandom_range(0, 15) == 0)
				rx_stall = $urandom_range(1, 16);
			if (rx_stall > 0) begin
				rx_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| cfg_wr_en)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic push_req(input logic req, input logic [1:0] cls,
			input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
			input logic [7:0] b3, input logic last);
		sample_t s;
		s.req  = req;
		s.cls  = cls;
		s.band = {b3, b2, b1, b0};
		s.last = last;
		pending_requests.push_back(s);
		n_queued++;
	endtask

	function automatic logic [7:0] jitter(input logic [7:0] c, input int amp);
		int v;
		v = int'(c) + int'($urandom_range(0, 2 * amp)) - amp;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	function automatic int pick_amp();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 2;
			2: return 8;
			default: return 40;
		endcase
	endfunction

	task automatic wait_drained();
		while (n_accepted != n_queued || expected_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_tolerance(input logic [fbtm_pkg::TOL_W-1:0] v);
		wait_drained();
		// a trailing training request may still be in the pipe
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tolerance = v;
	endtask

	// training near class centers, query groups aimed at a class or anywhere,
	// some unterminated groups and fully random requests
	task automatic gen_traffic(input int n);
		int      count;
		int      kind;
		int      glen;
		int      tgt;
		int      amp;
		bit      broken;
		logic [1:0] c;
		logic [7:0] bv [fbtm_pkg::NUM_BANDS];
		count = 0;
		while (count < n) begin
			kind = $urandom_range(0, 9);
			amp  = pick_amp();
			if (kind < 3) begin
				c = 2'($urandom_range(0, 3));
				for (int b = 0; b < fbtm_pkg::NUM_BANDS; b++)
					bv[b] = jitter(center[c][b], amp);
				push_req(fbtm_pkg::REQ_TRAIN, c, bv[0], bv[1], bv[2], bv[3],
					1'($urandom_range(0, 1)));
				count++;
			end else if (kind < 9) begin
				glen   = $urandom_range(1, 4);
				tgt    = $urandom_range(0, 4);
				broken = ($urandom_range(0, 7) == 0);
				for (int i = 0; i < glen; i++) begin
					for (int b = 0; b < fbtm_pkg::NUM_BANDS; b++)
						bv[b] = (tgt < 4) ? jitter(center[tgt][b], amp)
							: 8'($urandom_range(0, 255));
					push_req(fbtm_pkg::REQ_QUERY, 2'($urandom_range(0, 3)),
						bv[0], bv[1], bv[2], bv[3], (i == glen - 1) && !broken);
				end
				count += glen;
			end else begin
				push_req(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
				count++;
			end
		end
	endtask

	initial begin
		for (int c = 0; c < 3; c++)
			for (int b = 0; b < fbtm_pkg::NUM_BANDS; b++)
				center[c][b] = 8'($urandom_range(0, 255));
		// class 3 sits right next to class 2 so multiple matches show up
		for (int b = 0; b < fbtm_pkg::NUM_BANDS; b++)
			center[3][b] = (center[2][b] == 8'hFF) ? 8'hFE : center[2][b] + 8'd1;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// query against an empty store
		push_req(fbtm_pkg::REQ_QUERY, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		// tlast on a training request is ignored
		push_req(fbtm_pkg::REQ_TRAIN, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		push_req(fbtm_pkg::REQ_TRAIN, 2'd1, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
		push_req(fbtm_pkg::REQ_TRAIN, 2'd2, 8'd5, 8'd5, 8'd5, 8'd5, 1'b0);
		push_req(fbtm_pkg::REQ_TRAIN, 2'd3, 8'd128, 8'd0, 8'd255, 8'd64, 1'b0);
		push_req(fbtm_pkg::REQ_QUERY, 2'd3, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
		push_req(fbtm_pkg::REQ_QUERY, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		push_req(fbtm_pkg::REQ_QUERY, 2'd0, 8'd10, 8'd10, 8'd10, 8'd10, 1'b1);
		push_req(fbtm_pkg::REQ_QUERY, 2'd1, 8'd128, 8'd0, 8'd255, 8'd64, 1'b1);
		push_req(fbtm_pkg::REQ_QUERY, 2'd2, 8'd60, 8'd200, 8'd30, 8'd90, 1'b1);
		push_req(fbtm_pkg::REQ_TRAIN, 2'd0, 8'd1, 8'd2, 8'd3, 8'd4, 1'b0);
		push_req(fbtm_pkg::REQ_QUERY, 2'd0, 8'd255, 8'd0, 8'd255, 8'd0, 1'b1);
		push_req(fbtm_pkg::REQ_QUERY, 2'd0, 8'd1, 8'd1, 8'd2, 8'd3, 1'b1);

		write_tolerance('0);
		gen_traffic(220);
		write_tolerance('1);
		gen_traffic(150);
		for (int k = 0; k < 4; k++) begin
			write_tolerance(16'($urandom_range(0, 4000)));
			gen_traffic(200);
		end

		// sample limit: saturate class 1, then overfill the query so the
		// closing sample itself is dropped
		write_tolerance(fbtm_pkg::TOL_RESET);
		for (int i = 0; i < 230; i++)
			push_req(fbtm_pkg::REQ_TRAIN, 2'd1, jitter(center[1][0], 8),
				jitter(center[1][1], 8), jitter(center[1][2], 8),
				jitter(center[1][3], 8), 1'b0);
		for (int i = 0; i < 257; i++)
			push_req(fbtm_pkg::REQ_QUERY, 2'd0, jitter(center[1][0], 2),
				jitter(center[1][1], 2), jitter(center[1][2], 2),
				jitter(center[1][3], 2), i == 256);
		push_req(fbtm_pkg::REQ_QUERY, 2'd0, center[1][0], center[1][1], center[1][2],
			center[1][3], 1'b1);

		write_tolerance(16'($urandom_range(0, 65535)));
		calm = 1'b1;
		gen_traffic(250);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
